### design/max_flow_bfs_augmenting_core_assert.svh
// assertion macros for the max flow core
`ifndef MAX_FLOW_BFS_AUGMENTING_CORE_ASSERT_SVH
`define MAX_FLOW_BFS_AUGMENTING_CORE_ASSERT_SVH

// implication checked on every rising clock edge out of reset
`define MF_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication checked out of reset
`define MF_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### design/mfbfs_pkg.sv
package mfbfs_pkg;

    localparam int NODES    = 16;
    localparam int NODE_W   = 4;
    localparam int CAP_BITS = 16;
    localparam int RES_W    = 17;
    localparam int FLOW_W   = 20;
    localparam int ADDR_W   = 2 * NODE_W;
    localparam int DEPTH    = NODES * NODES;

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_RUN   = 1'b1;
    localparam logic ST_OK     = 1'b0;
    localparam logic ST_SAME   = 1'b1;

    typedef struct packed {
        logic                action;
        logic [NODE_W-1:0]   from_node;
        logic [NODE_W-1:0]   to_node;
        logic [CAP_BITS-1:0] edge_capacity;
        logic [NODE_W-1:0]   source_node;
        logic [NODE_W-1:0]   sink_node;
    } t_in;

    typedef struct packed {
        logic [FLOW_W-1:0] total_flow;
        logic              status;
    } t_out;

    // one residual memory port request from the sequencer
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [RES_W-1:0]  wdata;
    } t_mem_req;

endpackage

### design/max_flow_bfs_augmenting_core.sv
// Edmonds-Karp maximum flow over a 16-node dense graph. After reset busy stays high
// while the capacity memory is swept to zero. A write item (action 0) stores one
// capacity; busy stays low. A run item (action 1) with source unlike sink raises busy
// until the result strobe: the capacity memory is copied into the residual memory,
// then breadth-first searches alternate with augmentations along each found path,
// all through one residual memory port and one shared adder. Source equal to sink
// answers the next cycle with status 1. The result is shown for one cycle on o_valid
// and cannot be stalled.
module max_flow_bfs_augmenting_core import mfbfs_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    input  t_in  i_in,
    output logic busy,
    output logic o_valid,
    output t_out o_out
);

    logic [ADDR_W-1:0]   cap_raddr, res_raddr;
    logic [CAP_BITS-1:0] cap_rdata;
    logic [RES_W-1:0]    res_rdata;
    t_mem_req            res_wr;
    logic                go, done, r_busy, r_valid, r_status, r_capv, r_go;
    logic [NODE_W-1:0]   r_src, r_dst;
    logic [FLOW_W-1:0]   flow, r_total;
    logic [ADDR_W:0]     r_clr;
    logic                clearing, acc, wr_cap;

    assign clearing = !r_clr[ADDR_W];
    assign busy     = r_busy | clearing;
    assign acc      = start & !busy;
    assign wr_cap   = clearing | (acc & (i_in.action == ACT_WRITE));
    assign go       = acc & (i_in.action == ACT_RUN) & (i_in.source_node != i_in.sink_node);

    // capacity memory, cleared by a sweep after reset
    mfbfs_ram #(.WIDTH(CAP_BITS), .DEPTH(DEPTH)) u_cap (
        .i_clk(i_clk), .i_we(wr_cap),
        .i_waddr(clearing ? r_clr[ADDR_W-1:0] : {i_in.from_node, i_in.to_node}),
        .i_wdata(clearing ? '0 : i_in.edge_capacity),
        .i_raddr(cap_raddr), .o_rdata(cap_rdata)
    );

    mfbfs_ram #(.WIDTH(RES_W), .DEPTH(DEPTH)) u_res (
        .i_clk(i_clk), .i_we(res_wr.we), .i_waddr(res_wr.addr),
        .i_wdata(res_wr.wdata), .i_raddr(res_raddr), .o_rdata(res_rdata)
    );

    mfbfs_seq u_seq (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_go(go),
        .i_src(go ? i_in.source_node : r_src), .i_dst(go ? i_in.sink_node : r_dst),
        .o_cap_raddr(cap_raddr), .i_cap_rdata(cap_rdata), .i_cap_valid(r_capv),
        .o_res_wr(res_wr), .o_res_raddr(res_raddr), .i_res_rdata(res_rdata),
        .o_done(done), .o_flow(flow)
    );

    // run control and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0; r_valid <= 1'b0; r_clr <= '0; r_capv <= 1'b0;
            r_go <= 1'b0;
        end else begin
            if (clearing) r_clr <= r_clr + (ADDR_W+1)'(1);
            // read data valid once go has passed through r_go, until address zero comes round
            r_go    <= go;
            r_capv  <= r_go | (r_capv & (cap_raddr != ADDR_W'(0)));
            r_valid <= done | (acc & (i_in.action == ACT_RUN) & !go);
            if (go) r_busy <= 1'b1;
            else if (done) r_busy <= 1'b0;
        end
        if (go) begin
            r_src <= i_in.source_node; r_dst <= i_in.sink_node;
        end
        if (done) begin
            r_total <= flow; r_status <= ST_OK;
        end else if (acc) begin
            r_total <= '0; r_status <= ST_SAME;
        end
    end

    assign o_valid          = r_valid;
    assign o_out.total_flow = r_total;
    assign o_out.status     = r_status;

endmodule

### design/mfbfs_ram.sv
module mfbfs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // single write port, registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### design/mfbfs_seq.sv
module mfbfs_seq import mfbfs_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_go,
    input  logic [NODE_W-1:0] i_src,
    input  logic [NODE_W-1:0] i_dst,
    output logic [ADDR_W-1:0] o_cap_raddr,
    input  logic [CAP_BITS-1:0] i_cap_rdata,
    input  logic              i_cap_valid,
    output t_mem_req          o_res_wr,
    output logic [ADDR_W-1:0] o_res_raddr,
    input  logic [RES_W-1:0]  i_res_rdata,
    output logic              o_done,
    output logic [FLOW_W-1:0] o_flow
);

    typedef enum logic [10:0] {
        S_IDLE  = 11'b00000000001,
        S_COPY  = 11'b00000000010,
        S_BINIT = 11'b00000000100,
        S_POP   = 11'b00000001000,
        S_SCAN  = 11'b00000010000,
        S_MIN   = 11'b00000100000,
        S_MINW  = 11'b00001000000,
        S_FWD   = 11'b00010000000,
        S_FWDW  = 11'b00100000000,
        S_BWD   = 11'b01000000000,
        S_BWDW  = 11'b10000000000
    } t_state;

    localparam int CNT_W = ADDR_W + 1;

    t_state r_state, n_state;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [NODE_W:0]   r_n, n_n;
    logic [NODE_W-1:0] r_u, n_u;
    logic [NODE_W-1:0] r_x, n_x;
    logic [NODE_W:0]   r_guard, n_guard;
    logic [NODE_W:0]   r_head, n_head;
    logic [NODE_W:0]   r_tail, n_tail;
    logic [NODES-1:0]  r_vis, n_vis;
    logic [NODE_W-1:0] r_par [NODES];
    logic [NODE_W-1:0] r_que [NODES];
    logic [RES_W-1:0]  r_bn, n_bn;
    logic              r_first, n_first;
    logic [FLOW_W-1:0] r_flow, n_flow;
    logic              par_we, que_we;
    logic [NODE_W-1:0] par_idx, par_val, que_val, que_idx;
    logic [NODE_W-1:0] scan_n, px;
    logic [RES_W:0]    alu;

    assign scan_n = r_n[NODE_W-1:0];
    assign px     = r_par[r_x];
    // shared adder/subtractor for compare, subtract and add
    always_comb begin
        case (r_state)
            S_FWDW:  alu = {1'b0, i_res_rdata} - {1'b0, r_bn};
            S_BWDW:  alu = {1'b0, i_res_rdata} + {1'b0, r_bn};
            default: alu = {1'b0, i_res_rdata} - {1'b0, r_bn};
        endcase
    end

    // sequencer
    always_comb begin
        n_state = r_state; n_cnt = r_cnt; n_n = r_n; n_u = r_u; n_x = r_x;
        n_guard = r_guard; n_head = r_head; n_tail = r_tail; n_vis = r_vis;
        n_bn = r_bn; n_first = r_first; n_flow = r_flow;
        par_we = 1'b0; par_idx = '0; par_val = '0; que_we = 1'b0; que_val = '0;
        que_idx = r_tail[NODE_W-1:0];
        o_res_wr = '0;
        o_cap_raddr = r_cnt[ADDR_W-1:0];
        o_res_raddr = {r_u, scan_n};
        o_done = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_go) begin
                    n_state = S_COPY; n_cnt = '0; n_flow = '0;
                end
            end
            S_COPY: begin
                // capacity read is registered: write lags the address by one
                if (i_cap_valid) begin
                    o_res_wr.we    = 1'b1;
                    o_res_wr.addr  = r_cnt[ADDR_W-1:0] - ADDR_W'(1);
                    o_res_wr.wdata = {1'b0, i_cap_rdata};
                end
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(DEPTH)) n_state = S_BINIT;
            end
            S_BINIT: begin
                n_vis = '0; n_vis[i_src] = 1'b1;
                par_we = 1'b1; par_idx = i_src; par_val = i_src;
                que_we = 1'b1; que_val = i_src; que_idx = '0;
                n_head = '0; n_tail = (NODE_W+1)'(1);
                n_state = S_POP;
            end
            S_POP: begin
                if (r_head < r_tail) begin
                    n_u = r_que[r_head[NODE_W-1:0]];
                    n_head = r_head + (NODE_W+1)'(1);
                    n_n = '0; n_state = S_SCAN;
                end else if (r_vis[i_dst]) begin
                    n_x = i_dst; n_guard = '0; n_first = 1'b1; n_bn = '0;
                    n_state = S_MIN;
                end else begin
                    o_done = 1'b1; n_state = S_IDLE;
                end
            end
            S_SCAN: begin
                // r_n leads the data through the registered read; index 0..NODES
                o_res_raddr = {r_u, scan_n};
                n_n = r_n + (NODE_W+1)'(1);
                if (r_n != '0) begin
                    par_idx = scan_n - NODE_W'(1);
                    if (!r_vis[par_idx] && i_res_rdata != '0) begin
                        n_vis[par_idx] = 1'b1;
                        par_we = 1'b1; par_val = r_u;
                        if (r_tail < (NODE_W+1)'(NODES)) begin
                            que_we = 1'b1; que_val = par_idx;
                            n_tail = r_tail + (NODE_W+1)'(1);
                        end
                    end
                end
                if (r_n == (NODE_W+1)'(NODES)) n_state = S_POP;
            end
            S_MIN: begin
                if (r_x == i_src || r_guard == (NODE_W+1)'(NODES)) begin
                    if (r_bn == '0) begin
                        o_done = 1'b1; n_state = S_IDLE;
                    end else begin
                        n_x = i_dst; n_guard = '0; n_state = S_FWD;
                    end
                end else begin
                    o_res_raddr = {px, r_x};
                    n_state = S_MINW;
                end
            end
            S_MINW: begin
                if (r_first || alu[RES_W]) n_bn = i_res_rdata;
                n_first = 1'b0; n_x = px; n_guard = r_guard + (NODE_W+1)'(1);
                n_state = S_MIN;
            end
            S_FWD: begin
                if (r_x == i_src || r_guard == (NODE_W+1)'(NODES)) begin
                    n_flow = r_flow + FLOW_W'(r_bn);
                    n_state = S_BINIT;
                end else begin
                    o_res_raddr = {px, r_x};
                    n_state = S_FWDW;
                end
            end
            S_FWDW: begin
                o_res_wr.we = 1'b1; o_res_wr.addr = {px, r_x};
                o_res_wr.wdata = alu[RES_W-1:0];
                o_res_raddr = {r_x, px};
                n_state = S_BWD;
            end
            S_BWD: begin
                // hold the backward address so its data is there next cycle
                o_res_raddr = {r_x, px};
                n_state = S_BWDW;
            end
            S_BWDW: begin
                o_res_wr.we = 1'b1; o_res_wr.addr = {r_x, px};
                o_res_wr.wdata = alu[RES_W-1:0];
                n_x = px; n_guard = r_guard + (NODE_W+1)'(1);
                n_state = S_FWD;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_vis   <= '0;
            r_flow  <= '0;
        end else begin
            r_state <= n_state;
            r_vis   <= n_vis;
            r_flow  <= n_flow;
        end
        r_cnt <= n_cnt; r_n <= n_n; r_u <= n_u; r_x <= n_x; r_guard <= n_guard;
        r_head <= n_head; r_tail <= n_tail; r_bn <= n_bn; r_first <= n_first;
        if (par_we) r_par[par_idx] <= par_val;
        if (que_we) r_que[que_idx] <= que_val;
    end

    assign o_flow = r_flow;

endmodule

### design/mfbfs_checker.sv
`include "max_flow_bfs_augmenting_core_assert.svh"
module mfbfs_checker import mfbfs_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input t_in  i_in,
    input logic busy,
    input logic o_valid,
    input t_out o_out
);

    logic run_diff, run_same, wr_acc, same_ok;

    // accepted transfers by kind
    assign run_diff = start && !busy && i_in.action == ACT_RUN
                      && i_in.source_node != i_in.sink_node;
    assign run_same = start && !busy && i_in.action == ACT_RUN
                      && i_in.source_node == i_in.sink_node;
    assign wr_acc   = start && !busy && i_in.action == ACT_WRITE;
    assign same_ok  = o_valid && o_out.status == ST_SAME && o_out.total_flow == '0;

    // an accepted run with distinct endpoints is followed by busy
    `MF_ASSERT_NXT(a_run_busy, i_clk, i_rst_n, run_diff, busy)
    // equal endpoints answer next cycle with status set and zero flow
    `MF_ASSERT_NXT(a_same, i_clk, i_rst_n, run_same, same_ok)
    // a write never produces a result
    `MF_ASSERT_NXT(a_wr_quiet, i_clk, i_rst_n, wr_acc, !o_valid)
    // a result only shows while the block is idle
    `MF_ASSERT_IMP(a_valid_idle, i_clk, i_rst_n, o_valid, !busy)

endmodule

bind max_flow_bfs_augmenting_core mfbfs_checker u_chk (.*);
